// File: rtl/lookat_view_matrix_core_macros.svh
// ----------------------------------------------------------------------------
// Look-at view matrix core: assertion macros
// Shared property wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LOOKAT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define LVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define LVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/lvm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared types and constants of the front, queue and back end.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int COMP_W = 32;
  localparam int DIFF_W = 33;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // One queued transaction: up hint, eye and eye minus target
  typedef struct packed {
    comp_t up_x;
    comp_t up_y;
    comp_t up_z;
    comp_t eye_x;
    comp_t eye_y;
    comp_t eye_z;
    diff_t d_x;
    diff_t d_y;
    diff_t d_z;
  } item_t;

  // Queue control driven by the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NRM_START,
    ST_NRM_SHIFT,
    ST_MUL,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_NEXT,
    ST_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    MD_CROSS1,
    MD_CROSS2,
    MD_SQ,
    MD_DOT
  } mul_mode_t;

  typedef enum logic [1:0] {
    VEC_DIR   = 2'd0,
    VEC_RIGHT = 2'd1,
    VEC_UP    = 2'd2
  } vec_sel_t;

endpackage

// File: rtl/lvm_front.sv
// ----------------------------------------------------------------------------
// Look-at view matrix front end
// Accepts input transactions, forms eye minus target and pushes the queue.
// ----------------------------------------------------------------------------
module lvm_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  lvm_pkg::comp_t up_x,
  input  lvm_pkg::comp_t up_y,
  input  lvm_pkg::comp_t up_z,
  input  lvm_pkg::comp_t target_x,
  input  lvm_pkg::comp_t target_y,
  input  lvm_pkg::comp_t target_z,
  input  lvm_pkg::comp_t eye_x,
  input  lvm_pkg::comp_t eye_y,
  input  lvm_pkg::comp_t eye_z,
  input  logic          q_full,
  output logic          push,
  output lvm_pkg::item_t item
);

  // Hold off while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Build the queued item with exact 33-bit differences
  always_comb begin
    item.up_x  = up_x;
    item.up_y  = up_y;
    item.up_z  = up_z;
    item.eye_x = eye_x;
    item.eye_y = eye_y;
    item.eye_z = eye_z;
    item.d_x   = {eye_x[31], eye_x} - {target_x[31], target_x};
    item.d_y   = {eye_y[31], eye_y} - {target_y[31], target_y};
    item.d_z   = {eye_z[31], eye_z} - {target_z[31], target_z};
  end

endmodule

// File: rtl/lvm_queue.sv
// ----------------------------------------------------------------------------
// Look-at view matrix queue
// Two-entry register queue between the front and the back end.
// ----------------------------------------------------------------------------
module lvm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lvm_pkg::item_t din,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output lvm_pkg::item_t dout
);

  lvm_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/lvm_back.sv
// ----------------------------------------------------------------------------
// Look-at view matrix back end
// Normalizes, crosses and dots with one shared multiplier, an iterative
// square root and a restoring divider, then emits four rows.
// ----------------------------------------------------------------------------
module lvm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  lvm_pkg::item_t  q_item,
  output lvm_pkg::q_ctl_t q_ctl,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      row_index,
  output lvm_pkg::comp_t  elem_a,
  output lvm_pkg::comp_t  elem_b,
  output lvm_pkg::comp_t  elem_c,
  output lvm_pkg::comp_t  elem_d,
  output logic            degenerate,
  output logic            last_row
);

  localparam int QB     = FRAC_BITS + 2;
  localparam int QCNT_W = $clog2(QB);
  localparam logic [QCNT_W-1:0] QCNT_TOP = QCNT_W'(QB - 1);
  localparam logic [63:0] HI_LIM = 64'd1 << 30;
  localparam logic [63:0] LO_LIM = 64'd1 << 29;
  localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
  localparam lvm_pkg::comp_t ONE = lvm_pkg::comp_t'(64'd1 << FRAC_BITS);

  lvm_pkg::eng_state_t state, state_next;
  lvm_pkg::vec_sel_t   phase;
  lvm_pkg::mul_mode_t  mode;

  lvm_pkg::comp_t      up_v  [3];
  lvm_pkg::comp_t      eye_v [3];
  logic signed [63:0]  vin   [3];
  logic [63:0]         mag   [3];
  logic                neg   [3];
  logic [63:0]         mx;
  lvm_pkg::comp_t      nv    [3][3];
  logic                degen;

  logic [3:0]          kcnt;
  logic [3:0]          kc;
  logic [3:0]          knum;
  logic signed [32:0]  ma;
  logic signed [32:0]  mb;
  logic signed [65:0]  prod;
  logic signed [63:0]  hold;
  logic signed [63:0]  acc;
  logic signed [63:0]  sdot  [3];

  logic [63:0]         sq_n;
  logic [63:0]         sq_res;
  logic [63:0]         sq_bit;
  logic [4:0]          scnt;
  logic [63:0]         sq_try;

  logic [1:0]          ci;
  logic [63:0]         num_c;
  logic [32:0]         rem;
  logic [QB-1:0]       qin;
  logic [QB-1:0]       q;
  logic [QB-1:0]       q_next;
  logic [32:0]         r2;
  logic                qbit;
  logic [QCNT_W-1:0]   qcnt;
  lvm_pkg::comp_t      qext;

  logic [1:0]          row;
  logic [1:0]          row_sel;
  logic                out_load;
  logic [63:0]         m_c   [3];
  logic [63:0]         mx_c;

  // Cross product operand indexes per issue slot
  function automatic logic [1:0] cross_a(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd5: r = 2'd1;
      4'd1, 4'd2: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd3: r = 2'd2;
      4'd1, 4'd4: r = 2'd1;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // Dot product slot to row and column
  function automatic logic [1:0] dot_row(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dot_col(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Row of the translation part to the vector it dots with
  function automatic logic [1:0] dot_vec(input logic [1:0] r);
    logic [1:0] v;
    unique case (r)
      2'd0:    v = lvm_pkg::VEC_RIGHT;
      2'd1:    v = lvm_pkg::VEC_UP;
      default: v = lvm_pkg::VEC_DIR;
    endcase
    return v;
  endfunction

  // Round a dot product, negate and saturate
  function automatic lvm_pkg::comp_t round_neg(input logic signed [63:0] s);
    logic [63:0]    m;
    logic [63:0]    r;
    lvm_pkg::comp_t res;
    m = s[63] ? (~s + 64'd1) : s;
    r = (m + HALF_LSB) >> FRAC_BITS;
    if (s[63]) begin
      res = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : lvm_pkg::comp_t'(r[31:0]);
    end else begin
      res = (r > 64'h8000_0000) ? 32'sh8000_0000 : lvm_pkg::comp_t'(-r[31:0]);
    end
    return res;
  endfunction

  // Magnitudes and largest magnitude of the vector to normalize
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i] = vin[i][63] ? (~vin[i] + 64'd1) : vin[i];
    end
    mx_c = (m_c[0] > m_c[1]) ? m_c[0] : m_c[1];
    mx_c = (mx_c > m_c[2]) ? mx_c : m_c[2];
  end

  // Products per multiply pass
  always_comb begin
    unique case (mode)
      lvm_pkg::MD_CROSS1, lvm_pkg::MD_CROSS2: knum = 4'd6;
      lvm_pkg::MD_SQ:                         knum = 4'd3;
      default:                                knum = 4'd9;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mode)
      lvm_pkg::MD_CROSS1: begin
        ma = {up_v[cross_a(kcnt)][31], up_v[cross_a(kcnt)]};
        mb = {nv[lvm_pkg::VEC_DIR][cross_b(kcnt)][31], nv[lvm_pkg::VEC_DIR][cross_b(kcnt)]};
      end
      lvm_pkg::MD_CROSS2: begin
        ma = {nv[lvm_pkg::VEC_DIR][cross_a(kcnt)][31], nv[lvm_pkg::VEC_DIR][cross_a(kcnt)]};
        mb = {nv[lvm_pkg::VEC_RIGHT][cross_b(kcnt)][31],
              nv[lvm_pkg::VEC_RIGHT][cross_b(kcnt)]};
      end
      lvm_pkg::MD_SQ: begin
        if (kcnt < 4'd3) begin
          ma = {3'b000, mag[kcnt[1:0]][29:0]};
          mb = {3'b000, mag[kcnt[1:0]][29:0]};
        end
      end
      default: begin
        ma = {eye_v[dot_col(kcnt)][31], eye_v[dot_col(kcnt)]};
        mb = {nv[dot_vec(dot_row(kcnt))][dot_col(kcnt)][31],
              nv[dot_vec(dot_row(kcnt))][dot_col(kcnt)]};
      end
    endcase
  end

  assign kc = kcnt - 4'd1;

  // Square root and divider step logic
  always_comb begin
    sq_try = sq_res + sq_bit;
    num_c  = (mag[ci] << FRAC_BITS) + {33'd0, sq_res[31:1]};
    r2     = {rem[31:0], qin[QB-1]};
    qbit   = (r2 >= {1'b0, sq_res[31:0]});
    q_next = {q[QB-2:0], qbit};
    qext   = lvm_pkg::comp_t'(q_next);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lvm_pkg::ST_IDLE: begin
        if (q_valid) state_next = lvm_pkg::ST_NRM_START;
      end
      lvm_pkg::ST_NRM_START: begin
        state_next = (mx_c == 64'd0) ? lvm_pkg::ST_NEXT : lvm_pkg::ST_NRM_SHIFT;
      end
      lvm_pkg::ST_NRM_SHIFT: begin
        if (mx < HI_LIM && mx >= LO_LIM) state_next = lvm_pkg::ST_MUL;
      end
      lvm_pkg::ST_MUL: begin
        if (kcnt == knum) begin
          priority case (mode)
            lvm_pkg::MD_SQ:  state_next = lvm_pkg::ST_SQRT;
            lvm_pkg::MD_DOT: state_next = lvm_pkg::ST_EMIT;
            default:         state_next = lvm_pkg::ST_NRM_START;
          endcase
        end
      end
      lvm_pkg::ST_SQRT: begin
        if (scnt == 5'd0) state_next = lvm_pkg::ST_DIV_INIT;
      end
      lvm_pkg::ST_DIV_INIT: state_next = lvm_pkg::ST_DIV_STEP;
      lvm_pkg::ST_DIV_STEP: begin
        if (qcnt == '0) begin
          state_next = (ci == 2'd2) ? lvm_pkg::ST_NEXT : lvm_pkg::ST_DIV_INIT;
        end
      end
      lvm_pkg::ST_NEXT: state_next = lvm_pkg::ST_MUL;
      lvm_pkg::ST_EMIT: begin
        if (out_load && row == lvm_pkg::ROW_LAST) state_next = lvm_pkg::ST_IDLE;
      end
      default: state_next = lvm_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_ctl.valid = q_valid;
    q_ctl.pop   = (state == lvm_pkg::ST_IDLE) && q_valid;
    out_load    = (state == lvm_pkg::ST_EMIT) && (!out_valid || !out_stall);
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lvm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (state)
      lvm_pkg::ST_IDLE: begin
        up_v[0]  <= q_item.up_x;
        up_v[1]  <= q_item.up_y;
        up_v[2]  <= q_item.up_z;
        eye_v[0] <= q_item.eye_x;
        eye_v[1] <= q_item.eye_y;
        eye_v[2] <= q_item.eye_z;
        vin[0]   <= {{31{q_item.d_x[32]}}, q_item.d_x};
        vin[1]   <= {{31{q_item.d_y[32]}}, q_item.d_y};
        vin[2]   <= {{31{q_item.d_z[32]}}, q_item.d_z};
        phase    <= lvm_pkg::VEC_DIR;
        degen    <= 1'b0;
      end
      lvm_pkg::ST_NRM_START: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= m_c[i];
          neg[i] <= vin[i][63];
        end
        mx <= mx_c;
        // Zero vector: zero components, flag it
        if (mx_c == 64'd0) begin
          degen <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            nv[phase][i] <= '0;
          end
        end
      end
      lvm_pkg::ST_NRM_SHIFT: begin
        // Scale until the largest magnitude lies in [2^29, 2^30)
        if (mx >= HI_LIM) begin
          mx <= mx >> 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (mx < LO_LIM) begin
          mx <= mx << 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end else begin
          mode <= lvm_pkg::MD_SQ;
          kcnt <= 4'd0;
        end
      end
      lvm_pkg::ST_MUL: begin
        kcnt <= kcnt + 4'd1;
        if (kcnt != 4'd0) begin
          unique case (mode)
            lvm_pkg::MD_SQ: begin
              acc <= (kc == 4'd0) ? prod[63:0] : acc + prod[63:0];
              if (kcnt == knum) begin
                sq_n   <= acc + prod[63:0];
                sq_res <= 64'd0;
                sq_bit <= 64'd1 << 62;
                scnt   <= 5'd31;
              end
            end
            lvm_pkg::MD_DOT: begin
              acc <= (dot_col(kc) == 2'd0) ? prod[63:0] : acc + prod[63:0];
              if (dot_col(kc) == 2'd2) sdot[dot_row(kc)] <= acc + prod[63:0];
              row <= 2'd0;
            end
            default: begin
              // Pair up products into one cross component
              if (!kc[0]) hold <= prod[63:0];
              else        vin[kc[2:1]] <= hold - prod[63:0];
            end
          endcase
        end
      end
      lvm_pkg::ST_SQRT: begin
        // One result bit per cycle
        if (sq_n >= sq_try) begin
          sq_n   <= sq_n - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        scnt   <= scnt - 5'd1;
        ci     <= 2'd0;
      end
      lvm_pkg::ST_DIV_INIT: begin
        rem  <= 33'(num_c >> QB);
        qin  <= num_c[QB-1:0];
        q    <= '0;
        qcnt <= QCNT_TOP;
      end
      lvm_pkg::ST_DIV_STEP: begin
        // One quotient bit per cycle
        rem  <= qbit ? (r2 - {1'b0, sq_res[31:0]}) : r2;
        qin  <= qin << 1;
        q    <= q_next;
        qcnt <= qcnt - QCNT_W'(1);
        if (qcnt == '0) begin
          nv[phase][ci] <= neg[ci] ? -qext : qext;
          ci <= ci + 2'd1;
        end
      end
      lvm_pkg::ST_NEXT: begin
        kcnt <= 4'd0;
        unique case (phase)
          lvm_pkg::VEC_DIR: begin
            phase <= lvm_pkg::VEC_RIGHT;
            mode  <= lvm_pkg::MD_CROSS1;
          end
          lvm_pkg::VEC_RIGHT: begin
            phase <= lvm_pkg::VEC_UP;
            mode  <= lvm_pkg::MD_CROSS2;
          end
          default: mode <= lvm_pkg::MD_DOT;
        endcase
      end
      lvm_pkg::ST_EMIT: begin
        if (out_load) row <= row + 2'd1;
      end
      default: ;
    endcase
  end

  assign row_sel = (row == lvm_pkg::ROW_LAST) ? 2'd0 : row;

  // Output row register
  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index  <= row;
      degenerate <= degen;
      last_row   <= (row == lvm_pkg::ROW_LAST);
      if (row == lvm_pkg::ROW_LAST) begin
        elem_a <= round_neg(sdot[0]);
        elem_b <= round_neg(sdot[1]);
        elem_c <= round_neg(sdot[2]);
        elem_d <= ONE;
      end else begin
        elem_a <= nv[lvm_pkg::VEC_RIGHT][row_sel];
        elem_b <= nv[lvm_pkg::VEC_UP][row_sel];
        elem_c <= nv[lvm_pkg::VEC_DIR][row_sel];
        elem_d <= '0;
      end
    end
  end

endmodule

// File: rtl/lookat_view_matrix_core.sv
// ----------------------------------------------------------------------------
// Look-at view matrix core
// Builds a 4x4 view matrix from eye, target and up, emitted as four rows.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    up_*, target_*, eye_*
//   out      output     out_valid / out_stall  row_index, elem_a..d, flags
//
// Each transaction normalizes three vectors; each normalization scales the
// vector, then runs the back-end square-root and divide loops. A zero vector
// skips these and only zeroes its components. The front takes a new
// transaction into a two-entry queue while the back end works.
// Reset clears the queue, the sequencer and the output valid; no payload.
// A stalled output holds its row; the back end waits for it to drain.
// ----------------------------------------------------------------------------
`include "lookat_view_matrix_core_macros.svh"

module lookat_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   up_x,
  input  logic signed [31:0]   up_y,
  input  logic signed [31:0]   up_z,
  input  logic signed [31:0]   target_x,
  input  logic signed [31:0]   target_y,
  input  logic signed [31:0]   target_z,
  input  logic signed [31:0]   eye_x,
  input  logic signed [31:0]   eye_y,
  input  logic signed [31:0]   eye_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           row_index,
  output logic signed [31:0]   elem_a,
  output logic signed [31:0]   elem_b,
  output logic signed [31:0]   elem_c,
  output logic signed [31:0]   elem_d,
  output logic                 degenerate,
  output logic                 last_row
);

  logic            push;
  logic            q_full;
  logic            q_valid;
  lvm_pkg::item_t  f_item;
  lvm_pkg::item_t  q_item;
  lvm_pkg::q_ctl_t q_ctl;

  lvm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .up_x     (up_x),
    .up_y     (up_y),
    .up_z     (up_z),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .eye_x    (eye_x),
    .eye_y    (eye_y),
    .eye_z    (eye_z),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  lvm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .pop   (q_ctl.pop),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_item)
  );

  lvm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ctl      (q_ctl),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .elem_c     (elem_c),
    .elem_d     (elem_d),
    .degenerate (degenerate),
    .last_row   (last_row)
  );

  // Checks
  `LVM_ASSERT_IMP(a_pop_nonempty, clk, rst, q_ctl.pop, q_ctl.valid, "pop from empty queue")
  `LVM_ASSERT_NXT(a_pop_single, clk, rst, q_ctl.pop, !q_ctl.pop, "back end took two items")
  `LVM_ASSERT_IMP(a_last_row, clk, rst, out_valid && last_row, row_index == lvm_pkg::ROW_LAST, "last row index")
  `LVM_ASSERT_IMP(a_rot_elem_d, clk, rst, out_valid && !last_row, elem_d == '0, "nonzero fourth element")

endmodule

// File: bench/lookat_view_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// Look-at view matrix core testbench
// Drives eye, target and up vectors through the valid/stall channel, computes
// the expected four matrix rows per transaction and checks every output row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lookat_view_matrix_core_tb;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 240;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [31:0] ONE_Q = 32'sh0001_0000;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic        degen;
    logic        last;
  } row_t;

  typedef struct {
    logic [31:0] v[9];
    logic        has_row3;
    logic [31:0] row3_a;
    logic        row3_degen;
  } vec_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] row_index;
  logic signed [31:0] elem_a, elem_b, elem_c, elem_d;
  logic degenerate, last_row;

  row_t expected_rows[$];
  int   errors = 0;
  longint cycles = 0;

  lookat_view_matrix_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
    .elem_a(elem_a), .elem_b(elem_b), .elem_c(elem_c), .elem_d(elem_d),
    .degenerate(degenerate), .last_row(last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale to [2^29, 2^30), divide by the integer length; returns zero flag
  function automatic bit unit_vector(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned mx = 0;
    longint unsigned len, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross3v(input longint a[3], input longint b[3],
                                  output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Negated, rounded and saturated eye dot axis
  function automatic logic [31:0] translation(input longint e[3], input longint u[3]);
    longint s = e[0] * u[0] + e[1] * u[1] + e[2] * u[2];
    longint unsigned r = (abs64(s) + (64'd1 << (FRAC - 1))) >> FRAC;
    longint res;
    if (r > (64'd1 << 32)) r = 64'd1 << 32;
    res = s < 0 ? longint'(r) : -longint'(r);
    if (res > 2147483647) res = 2147483647;
    if (res < -longint'(2147483647) - 1) res = -longint'(2147483647) - 1;
    return res[31:0];
  endfunction

  // Queue the four matrix rows one camera transaction yields
  task automatic predict_view_rows(input logic [31:0] v[9]);
    longint up[3], eye[3], diff[3], fwd[3], side[3], upc[3], tmp[3];
    logic [31:0] t[3];
    bit degen;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      up[i] = longint'($signed(v[i]));
      eye[i] = longint'($signed(v[6 + i]));
      diff[i] = eye[i] - longint'($signed(v[3 + i]));
    end
    degen = unit_vector(diff, fwd);
    cross3v(up, fwd, tmp);
    degen |= unit_vector(tmp, side);
    cross3v(fwd, side, tmp);
    degen |= unit_vector(tmp, upc);
    t[0] = translation(eye, side);
    t[1] = translation(eye, upc);
    t[2] = translation(eye, fwd);
    for (int k = 0; k < 4; k++) begin
      r.row = k[1:0];
      r.degen = degen;
      r.last = (k == 3);
      if (k < 3) begin
        r.a = side[k][31:0]; r.b = upc[k][31:0]; r.c = fwd[k][31:0]; r.d = '0;
      end else begin
        r.a = t[0]; r.b = t[1]; r.c = t[2]; r.d = ONE_Q;
      end
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  // Check each accepted output row against the oldest expectation
  always @(posedge clk) begin
    row_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row", {30'd0, row_index}, '0);
      end else begin
        w = expected_rows.pop_front();
        if (row_index !== w.row) report_mismatch("row_index", row_index, w.row);
        if (elem_a !== w.a) report_mismatch("elem_a", elem_a, w.a);
        if (elem_b !== w.b) report_mismatch("elem_b", elem_b, w.b);
        if (elem_c !== w.c) report_mismatch("elem_c", elem_c, w.c);
        if (elem_d !== w.d) report_mismatch("elem_d", elem_d, w.d);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
        if (last_row !== w.last) report_mismatch("last_row", last_row, w.last);
      end
    end
  end

  // Stall the output at random, with quiet stretches
  initial begin
    int wait_n;
    @(posedge clk iff !rst);
    forever begin
      wait_n = (cycles / 3000) % 4 == 1 ? 0 : $urandom_range(0, 10);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Present one transaction and hold it until taken
  task automatic send_camera(input logic [31:0] v[9]);
    int gap = (cycles / 3000) % 4 == 2 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {up_x, up_y, up_z} <= {v[0], v[1], v[2]};
    {target_x, target_y, target_z} <= {v[3], v[4], v[5]};
    {eye_x, eye_y, eye_z} <= {v[6], v[7], v[8]};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_view_rows(v);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  initial begin
    vec_case_t dir_tab[$];
    vec_case_t c;
    logic [31:0] v[9];
    int unsigned row_tot;
    // Directed rows: up, target, eye; a few expect a known translation x
    dir_tab.push_back('{'{0, ONE_Q, 0, 0, 0, 0, 0, 0, 5 * ONE_Q}, 0, 0, 0});
    // eye equals target: all axes zero, degenerate set, translation zero
    dir_tab.push_back('{'{0, ONE_Q, 0, 7, 7, 7, 7, 7, 7}, 1, 0, 1});
    // up parallel to view direction: right vanishes
    dir_tab.push_back('{'{0, 0, ONE_Q, 0, 0, 0, 0, 0, ONE_Q}, 1, 0, 1});
    // zero up hint
    dir_tab.push_back('{'{0, 0, 0, 0, 0, 0, ONE_Q, 0, 0}, 1, 0, 1});
    dir_tab.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 0, 0, 0});
    dir_tab.push_back('{'{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 0, 0, 0});
    dir_tab.push_back('{'{1, 32'hffff_ffff, 1, 0, 1, 0, 1, 0, 0}, 0, 0, 0});
    dir_tab.push_back('{'{0, ONE_Q, 0, 0, 0, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff}, 0, 0, 0});
    dir_tab.push_back('{'{0, 32'hffff_0000, 0, 32'h8000_0000, 0, 0,
                          32'h7fff_ffff, 0, 0}, 0, 0, 0});
    dir_tab.push_back('{'{32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff,
                          32'h5555_5555, 32'haaaa_aaaa, 0,
                          32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff}, 0, 0, 0});
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      c = dir_tab[i];
      send_camera(c.v);
      // Typed-in expectation for the obvious rows
      if (c.has_row3) begin
        row_tot = expected_rows.size();
        if (expected_rows[row_tot - 1].a !== c.row3_a)
          report_mismatch("table row3", expected_rows[row_tot - 1].a, c.row3_a);
        if (expected_rows[row_tot - 1].degen !== c.row3_degen)
          report_mismatch("table degen", expected_rows[row_tot - 1].degen, c.row3_degen);
      end
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      foreach (v[i]) v[i] = rand_comp();
      // Occasionally land the eye on the target or zero the up hint
      if ($urandom_range(0, 15) == 0) {v[6], v[7], v[8]} = {v[3], v[4], v[5]};
      if ($urandom_range(0, 15) == 0) {v[0], v[1], v[2]} = '0;
      send_camera(v);
    end
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
